@@ src/kqsb_pkg.sv @@
`default_nettype none

package kqsb_pkg;

    localparam int ENTRIES = 32;
    localparam int QUEUES  = 8;

    localparam int ENT_W   = $clog2(ENTRIES);
    localparam int IDX_W   = $clog2(ENTRIES + 1);
    localparam int QUEUE_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int QNUM_W  = 8;
    localparam int DATA_W  = 32;

    // index one past the store marks an empty list
    localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(ENTRIES);

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2,
        STATUS_BADQ  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

endpackage

`default_nettype wire

@@ src/kqsb_ram.sv @@
`default_nettype none

module kqsb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ src/k_queues_shared_buffer.sv @@
`default_nettype none

// Several FIFO queues sharing one entry store through linked lists and a
// common free list.
// Command channel: a beat (opcode, queue_number, data_in) is taken at a
// rising edge with start high and busy low. opcode 0 enqueues data_in on
// queue queue_number (1 up to the queue count), opcode 1 dequeues from it.
// Result channel: done is high for exactly one cycle with data_out and
// status; the receiver cannot hold results off. status is 0 ok, 1 store
// full, 2 queue empty, 3 bad queue number; data_out is zero unless a
// dequeue succeeds, and an error leaves the queues untouched.
// Execution: the edge that takes the command beat registers it and enters
// the execute state, with busy high; done, data_out and status are registered
// from that state. No new command is taken while busy: the link store and
// data store have registered reads and are written in the execute state.
// Reset: all queues empty, every entry on the free list in index order;
// the link store is brought to its chain through per-entry valid bits, so
// commands are taken from the first cycle after reset.

module k_queues_shared_buffer
    import kqsb_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic                     opcode,
    input  wire logic        [QNUM_W-1:0] queue_number,
    input  wire logic signed [DATA_W-1:0] data_in,
    output logic                          busy,
    output logic                          done,
    output logic signed      [DATA_W-1:0] data_out,
    output logic             [1:0]        status
);

    state_t state_reg, state_next;

    logic [IDX_W-1:0]   free_head_reg, free_head_next;
    logic [IDX_W-1:0]   head_reg [QUEUES];
    logic [IDX_W-1:0]   tail_reg [QUEUES];
    logic [ENTRIES-1:0] link_vld_reg;

    op_t                op_reg;
    logic [QUEUE_W-1:0] q_reg;
    logic               bad_reg;
    logic [DATA_W-1:0]  din_reg;
    logic               link_vld_q_reg;

    logic               done_reg, done_next;
    logic [DATA_W-1:0]  data_out_reg, data_out_next;
    status_t            status_reg, status_next;

    logic               accept;
    logic               bad_in;
    logic [QUEUE_W-1:0] q_in;
    logic [ENT_W-1:0]   link_raddr;
    logic [ENT_W-1:0]   data_raddr;

    logic [IDX_W-1:0]   head_q;
    logic [IDX_W-1:0]   tail_q;
    logic [ENT_W-1:0]   rd_idx;
    logic [IDX_W-1:0]   link_rd;
    logic [IDX_W-1:0]   link_val;
    logic [DATA_W-1:0]  data_rd;

    logic               head_we;
    logic [IDX_W-1:0]   head_wdata;
    logic               tail_we;
    logic               link_we;
    logic [ENT_W-1:0]   link_waddr;
    logic [IDX_W-1:0]   link_wdata;
    logic               data_we;

    assign busy   = (state_reg == ST_EXEC);
    assign accept = start && (state_reg == ST_IDLE);

    // command decode on the incoming beat
    assign bad_in = (queue_number == '0) || (queue_number > QNUM_W'(QUEUES));
    assign q_in   = QUEUE_W'(queue_number - QNUM_W'(1));

    always_comb
    begin
        if (op_t'(opcode) == OP_ENQ)
        begin
            link_raddr = free_head_reg[ENT_W-1:0];
        end
        else
        begin
            link_raddr = head_reg[q_in][ENT_W-1:0];
        end
        data_raddr = head_reg[q_in][ENT_W-1:0];
    end

    kqsb_ram #(
        .WIDTH (IDX_W),
        .DEPTH (ENTRIES)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rd)
    );

    kqsb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (ENTRIES)
    ) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (free_head_reg[ENT_W-1:0]),
        .wdata (din_reg),
        .raddr (data_raddr),
        .rdata (data_rd)
    );

    assign head_q = head_reg[q_reg];
    assign tail_q = tail_reg[q_reg];
    assign rd_idx = (op_reg == OP_ENQ) ? free_head_reg[ENT_W-1:0] : head_q[ENT_W-1:0];

    // unwritten link entries read as the reset chain
    assign link_val = link_vld_q_reg ? link_rd : (IDX_W'(rd_idx) + IDX_W'(1));

    always_comb
    begin
        state_next     = state_reg;
        free_head_next = free_head_reg;
        head_we        = 1'b0;
        head_wdata     = link_val;
        tail_we        = 1'b0;
        link_we        = 1'b0;
        link_waddr     = tail_q[ENT_W-1:0];
        link_wdata     = free_head_reg;
        data_we        = 1'b0;
        done_next      = 1'b0;
        data_out_next  = '0;
        status_next    = STATUS_OK;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                if (bad_reg)
                begin
                    status_next = STATUS_BADQ;
                end
                else if (op_reg == OP_ENQ)
                begin
                    if (free_head_reg == NULL_IDX)
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        free_head_next = link_val;
                        tail_we        = 1'b1;
                        data_we        = 1'b1;
                        if (head_q == NULL_IDX)
                        begin
                            head_we    = 1'b1;
                            head_wdata = free_head_reg;
                        end
                        else
                        begin
                            link_we    = 1'b1;
                            link_waddr = tail_q[ENT_W-1:0];
                            link_wdata = free_head_reg;
                        end
                    end
                end
                else
                begin
                    if (head_q == NULL_IDX)
                    begin
                        status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        // last entry of the queue: tail link is never relied on
                        head_we        = 1'b1;
                        head_wdata     = (head_q == tail_q) ? NULL_IDX : link_val;
                        link_we        = 1'b1;
                        link_waddr     = head_q[ENT_W-1:0];
                        link_wdata     = free_head_reg;
                        free_head_next = head_q;
                        data_out_next  = data_rd;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            free_head_reg <= '0;
            link_vld_reg  <= '0;
            done_reg      <= 1'b0;
            for (int i = 0; i < QUEUES; i++)
            begin
                head_reg[i] <= NULL_IDX;
            end
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            done_reg      <= done_next;
            if (head_we)
            begin
                head_reg[q_reg] <= head_wdata;
            end
            if (link_we)
            begin
                link_vld_reg[link_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg         <= op_t'(opcode);
            q_reg          <= q_in;
            bad_reg        <= bad_in;
            din_reg        <= $unsigned(data_in);
            link_vld_q_reg <= link_vld_reg[link_raddr];
        end
        if (tail_we)
        begin
            tail_reg[q_reg] <= free_head_reg;
        end
        data_out_reg <= data_out_next;
        status_reg   <= status_next;
    end

    assign done     = done_reg;
    assign data_out = $signed(data_out_reg);
    assign status   = status_reg;

endmodule

`default_nettype wire

@@ verif/tb_k_queues_shared_buffer.sv @@
`timescale 1ns / 100ps

module tb_k_queues_shared_buffer;
    import kqsb_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BEATS = 1280;
    localparam int PHASE_BEATS  = 40;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     opcode;
    logic        [QNUM_W-1:0] queue_number;
    logic signed [DATA_W-1:0] data_in;
    logic                     busy;
    logic                     done;
    logic signed [DATA_W-1:0] data_out;
    logic        [1:0]        status;

    // shadow copy of the queue lists
    logic        [IDX_W-1:0]  head_of [QUEUES];
    logic        [IDX_W-1:0]  tail_of [QUEUES];
    logic        [IDX_W-1:0]  next_of [ENTRIES];
    logic signed [DATA_W-1:0] stored_value [ENTRIES];
    logic        [IDX_W-1:0]  free_top;

    logic signed [DATA_W-1:0] pending_data[$];
    status_t                  pending_status[$];

    int  mismatches = 0;
    int  cycles = 0;
    bit  steady = 1'b0;

    k_queues_shared_buffer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .opcode       (opcode),
        .queue_number (queue_number),
        .data_in      (data_in),
        .busy         (busy),
        .done         (done),
        .data_out     (data_out),
        .status       (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("k_queues_shared_buffer: mismatch");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("%0t ns: %s", $time, what);
        mismatches++;
    endtask

    // works out the result of one command and advances the shadow lists
    function automatic void predict_queue_op(input op_t op,
                                             input logic [QNUM_W-1:0] qn,
                                             input logic signed [DATA_W-1:0] din);
        int                       q;
        logic        [IDX_W-1:0]  idx;
        logic signed [DATA_W-1:0] dout;
        status_t                  st;
        dout = '0;
        st   = STATUS_OK;
        if (qn < 1 || qn > QUEUES)
            st = STATUS_BADQ;
        else
        begin
            q = qn - 1;
            if (op == OP_ENQ)
            begin
                idx = free_top;
                if (idx >= ENTRIES)
                    st = STATUS_FULL;
                else
                begin
                    free_top = next_of[idx];
                    if (head_of[q] >= ENTRIES)
                        head_of[q] = idx;
                    else if (tail_of[q] < ENTRIES)
                        next_of[tail_of[q]] = idx;
                    next_of[idx]      = NULL_IDX;
                    tail_of[q]        = idx;
                    stored_value[idx] = din;
                end
            end
            else
            begin
                idx = head_of[q];
                if (idx >= ENTRIES)
                    st = STATUS_EMPTY;
                else
                begin
                    head_of[q]   = next_of[idx];
                    next_of[idx] = free_top;
                    free_top     = idx;
                    dout         = stored_value[idx];
                end
            end
        end
        pending_data.push_back(dout);
        pending_status.push_back(st);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 25);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_data();
        case ($urandom_range(0, 19))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [QNUM_W-1:0] pick_queue();
        if ($urandom_range(0, 99) < 88)
            return QNUM_W'($urandom_range(1, QUEUES));
        else
            return QNUM_W'($urandom_range(0, 255));
    endfunction

    task automatic send_command(input op_t op, input logic [QNUM_W-1:0] qn,
                                input logic signed [DATA_W-1:0] din);
        int gap;
        gap = steady ? 0 : pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            start = 1'b0;
        end
        @(negedge clk);
        start        = 1'b1;
        opcode       = op;
        queue_number = qn;
        data_in      = din;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_queue_op(op, qn, din);
    endtask

    always @(posedge clk)
    begin : check_results
        logic signed [DATA_W-1:0] want_data;
        status_t                  want_status;
        if (rst_n && done)
        begin
            if (pending_status.size() == 0)
                report_mismatch("result beat with nothing pending");
            else
            begin
                want_data   = pending_data.pop_front();
                want_status = pending_status.pop_front();
                if (data_out !== want_data)
                    report_mismatch($sformatf("data_out %0d, expected %0d",
                                              data_out, want_data));
                if (status !== want_status)
                    report_mismatch($sformatf("status %0d, expected %s",
                                              status, want_status.name()));
            end
        end
    end

    task automatic test_bad_queue();
        send_command(OP_ENQ, '0, 32'sd17);
        send_command(OP_DEQ, '0, 32'sd0);
        send_command(OP_ENQ, QNUM_W'(QUEUES + 1), -32'sd1);
        send_command(OP_DEQ, QNUM_W'(QUEUES + 1), 32'sd0);
        send_command(OP_ENQ, 8'd255, 32'sh7fff_ffff);
        send_command(OP_DEQ, 8'd128, 32'sh8000_0000);
    endtask

    task automatic test_empty_dequeue();
        send_command(OP_DEQ, 8'd1, 32'sd5);
        send_command(OP_DEQ, QNUM_W'(QUEUES), 32'sd0);
    endtask

    task automatic test_data_extremes();
        send_command(OP_ENQ, 8'd1, 32'sh8000_0000);
        send_command(OP_ENQ, 8'd1, 32'sh7fff_ffff);
        send_command(OP_ENQ, QNUM_W'(QUEUES), '0);
        send_command(OP_ENQ, 8'd1, -32'sd1);
        send_command(OP_DEQ, 8'd1, '0);
        send_command(OP_DEQ, QNUM_W'(QUEUES), '0);
        send_command(OP_DEQ, 8'd1, '0);
        send_command(OP_DEQ, 8'd1, '0);
    endtask

    // stale tail after a queue runs dry
    task automatic test_drain_and_refill();
        send_command(OP_ENQ, 8'd2, 32'sd100);
        send_command(OP_DEQ, 8'd2, '0);
        send_command(OP_DEQ, 8'd2, '0);
        send_command(OP_ENQ, 8'd2, 32'sd200);
        send_command(OP_ENQ, 8'd2, 32'sd300);
        send_command(OP_DEQ, 8'd2, '0);
        send_command(OP_DEQ, 8'd2, '0);
    endtask

    task automatic test_store_full();
        steady = 1'b1;
        repeat (ENTRIES)
            send_command(OP_ENQ, QNUM_W'($urandom_range(1, QUEUES)), pick_data());
        repeat (3)
            send_command(OP_ENQ, QNUM_W'($urandom_range(1, QUEUES)), pick_data());
        steady = 1'b0;
        send_command(OP_DEQ, QNUM_W'($urandom_range(1, QUEUES)), pick_data());
        send_command(OP_ENQ, QNUM_W'($urandom_range(1, QUEUES)), pick_data());
        for (int q = 1; q <= QUEUES; q++)
        begin
            while (head_of[q-1] != NULL_IDX)
                send_command(OP_DEQ, QNUM_W'(q), pick_data());
        end
    endtask

    // phases with different enqueue bias so the store fills and drains
    task automatic test_random_traffic(input int beats);
        int   bias;
        op_t  op;
        for (int n = 0; n < beats; n++)
        begin
            if (n % PHASE_BEATS == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       bias = 20;
                    1:       bias = 50;
                    2:       bias = 75;
                    default: bias = 95;
                endcase
                steady = ($urandom_range(0, 3) == 0);
            end
            op = ($urandom_range(0, 99) < bias) ? OP_ENQ : OP_DEQ;
            send_command(op, pick_queue(), pick_data());
        end
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        opcode       = 1'b0;
        queue_number = '0;
        data_in      = '0;
        for (int q = 0; q < QUEUES; q++)
        begin
            head_of[q] = NULL_IDX;
            tail_of[q] = '0;
        end
        for (int e = 0; e < ENTRIES; e++)
        begin
            next_of[e]      = IDX_W'(e + 1);
            stored_value[e] = '0;
        end
        free_top = '0;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_bad_queue();
        test_empty_dequeue();
        test_data_extremes();
        test_drain_and_refill();
        test_store_full();
        test_random_traffic(RANDOM_BEATS);

        @(negedge clk);
        start = 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
        if (mismatches == 0)
            $display("k_queues_shared_buffer: match");
        else
            $display("k_queues_shared_buffer: mismatch");
        $finish;
    end

endmodule
